### sv/sroiec_pkg.sv
// Shared constants and types of the spectrum ROI event counter.
`timescale 1ns / 1ps

package sroiec_pkg;

  // Regions held in hardware, and how many of them count
  localparam int MaxRegions = 3;
  localparam int NumRegions = 3;

  localparam int WordW    = 16;
  localparam int TagW     = 4;
  localparam int PayloadW = 12;
  localparam int KindW    = 2;
  localparam int PixelW   = 24;
  localparam int CountW   = 32;
  localparam int DataW    = 32;
  localparam int AddrW    = 5;
  localparam int RegIdxW  = 3;

  // Event tags
  localparam logic [TagW-1:0] TagCount = 4'd1;
  localparam logic [TagW-1:0] TagPixel = 4'd8;
  localparam logic [TagW-1:0] TagIndex = 4'd10;
  localparam logic [TagW-1:0] TagLine  = 4'd11;

  // Result kinds
  localparam logic [KindW-1:0] KindPixel = 2'd0;
  localparam logic [KindW-1:0] KindIndex = 2'd1;
  localparam logic [KindW-1:0] KindLine  = 2'd2;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegRoi0First = 3'd0;
  localparam logic [RegIdxW-1:0] RegRoi0Last  = 3'd1;
  localparam logic [RegIdxW-1:0] RegRoi1First = 3'd2;
  localparam logic [RegIdxW-1:0] RegRoi1Last  = 3'd3;
  localparam logic [RegIdxW-1:0] RegRoi2First = 3'd4;
  localparam logic [RegIdxW-1:0] RegRoi2Last  = 3'd5;
  localparam logic [RegIdxW-1:0] RegScanWidth = 3'd6;
  localparam logic [RegIdxW-1:0] RegScanHeight = 3'd7;

  // Reset values of the registers
  localparam logic [PayloadW-1:0] RoiFirstRst = 12'd1;
  localparam logic [PayloadW-1:0] RoiLastRst  = 12'd0;
  localparam logic [PayloadW-1:0] ScanDimRst  = 12'd1;

  typedef logic [PayloadW-1:0] chan_t;
  typedef logic [CountW-1:0]   count_t;

endpackage

### sv/sroiec_evt_if.sv
// Event word stream channel.
`timescale 1ns / 1ps

interface sroiec_evt_if;
  import sroiec_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] event_word;

  modport source (output valid, output event_word, input ready);
  modport sink   (input valid, input event_word, output ready);
endinterface

### sv/sroiec_res_if.sv
// Result stream channel.
`timescale 1ns / 1ps

interface sroiec_res_if;
  import sroiec_pkg::*;

  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [PixelW-1:0]   pixel_index;
  logic [CountW-1:0]   word_index;
  logic [PayloadW-1:0] marker_value;
  logic [CountW-1:0]   roi0_total;
  logic [CountW-1:0]   roi1_total;
  logic [CountW-1:0]   roi2_total;
  logic                scan_done;

  modport source (
    output valid, output kind, output pixel_index, output word_index,
    output marker_value, output roi0_total, output roi1_total, output roi2_total,
    output scan_done, input ready
  );
  modport sink (
    input valid, input kind, input pixel_index, input word_index,
    input marker_value, input roi0_total, input roi1_total, input roi2_total,
    input scan_done, output ready
  );
endinterface

### sv/spectrum_roi_event_counter_unit.sv
// Top level of the spectrum ROI event counter: register port, counters and result register.
`timescale 1ns / 1ps

//  channel   direction  handshake          payload
//  evt_i     in         valid / ready      event_word[15:0]
//  res_o     out        valid / ready      kind, pixel_index, word_index, marker_value,
//                                          roi0..2_total, scan_done
//  APB       in / out   psel, penable      paddr[4:2] register, pwdata / prdata 32 bit
//
//  One item per cycle sustained while the result side keeps taking results; a result is
//  valid once its item has passed the input register and then the result register.
//  The single stage between those registers sets the rate: decode, window compare
//  and a 32-bit increment per region and for the word count, 24-bit for the pixel count.
//  Reset clears counters, accumulators and valid flags and loads register defaults.
//  A stalled result holds the result register and the item behind it; the input
//  stays ready while the input register is empty or the result register is free
//  or being taken.
module spectrum_roi_event_counter_unit
  import sroiec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  sroiec_evt_if.sink       evt_i,
  sroiec_res_if.source     res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Configuration registers
  chan_t               roi_first_q [MaxRegions];
  chan_t               roi_last_q  [MaxRegions];
  logic [PayloadW-1:0] scan_w_q, scan_h_q;
  logic [PixelW-1:0]   scan_total_q;

  logic               cfg_we;
  logic [RegIdxW-1:0] cfg_idx;
  chan_t              cfg_val;

  // Input stage
  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_adv, fire;

  // Block state
  count_t            acc_q [MaxRegions];
  logic [PixelW-1:0] pix_cnt_q;
  count_t            word_cnt_q;

  // Item decode
  logic [TagW-1:0]     tag;
  chan_t               payload;
  logic                is_count, is_pixel, is_index, is_line, emit, done;
  logic [MaxRegions-1:0] hit;

  // Result register
  logic                out_valid_q;
  logic [KindW-1:0]    kind_q;
  logic [PixelW-1:0]   pix_idx_q;
  count_t              word_idx_q;
  chan_t               marker_q;
  count_t              total_q [MaxRegions];
  logic                done_q;

  // ---------------------------------------------------------------------------
  // Register port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];
  assign cfg_val = pwdata[PayloadW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxRegions; r++) begin
        roi_first_q[r] <= RoiFirstRst;
        roi_last_q[r]  <= RoiLastRst;
      end
      scan_w_q <= ScanDimRst;
      scan_h_q <= ScanDimRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegRoi0First:  roi_first_q[0] <= cfg_val;
        RegRoi0Last:   roi_last_q[0]  <= cfg_val;
        RegRoi1First:  roi_first_q[1] <= cfg_val;
        RegRoi1Last:   roi_last_q[1]  <= cfg_val;
        RegRoi2First:  roi_first_q[2] <= cfg_val;
        RegRoi2Last:   roi_last_q[2]  <= cfg_val;
        RegScanWidth:  scan_w_q       <= cfg_val;
        RegScanHeight: scan_h_q       <= cfg_val;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegRoi0First:  prdata = DataW'(roi_first_q[0]);
      RegRoi0Last:   prdata = DataW'(roi_last_q[0]);
      RegRoi1First:  prdata = DataW'(roi_first_q[1]);
      RegRoi1Last:   prdata = DataW'(roi_last_q[1]);
      RegRoi2First:  prdata = DataW'(roi_first_q[2]);
      RegRoi2Last:   prdata = DataW'(roi_last_q[2]);
      RegScanWidth:  prdata = DataW'(scan_w_q);
      RegScanHeight: prdata = DataW'(scan_h_q);
    endcase
  end

  // Scan size product, registered in the cycle after the dimension registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_total_q <= PixelW'(1);
    end else begin
      scan_total_q <= PixelW'({12'd0, scan_w_q} * {12'd0, scan_h_q});
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: advance whenever the result register is free or being taken
  assign s1_adv      = ~out_valid_q | res_o.ready;
  assign evt_i.ready = ~s1_valid_q | s1_adv;
  assign fire        = s1_valid_q & s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_word_q <= evt_i.event_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and window compare
  assign tag      = s1_word_q[WordW-1:PayloadW];
  assign payload  = s1_word_q[PayloadW-1:0];
  assign is_count = (tag == TagCount);
  assign is_pixel = (tag == TagPixel);
  assign is_index = (tag == TagIndex);
  assign is_line  = (tag == TagLine);
  assign emit     = is_pixel | is_index | is_line;
  assign done     = is_line & (pix_cnt_q == scan_total_q);

  always_comb begin
    for (int r = 0; r < MaxRegions; r++) begin
      hit[r] = (r < NumRegions) && (payload >= roi_first_q[r]) && (payload <= roi_last_q[r]);
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxRegions; r++) begin
        acc_q[r] <= '0;
      end
      pix_cnt_q  <= '0;
      word_cnt_q <= '0;
    end else if (fire) begin
      for (int r = 0; r < MaxRegions; r++) begin
        if (is_pixel) begin
          acc_q[r] <= '0;
        end else if (is_count && hit[r]) begin
          acc_q[r] <= acc_q[r] + 1'b1;
        end
      end
      if (done) begin
        pix_cnt_q  <= '0;
        word_cnt_q <= '0;
      end else begin
        word_cnt_q <= word_cnt_q + 1'b1;
        if (is_pixel) begin
          pix_cnt_q <= pix_cnt_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= emit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q     <= is_pixel ? KindPixel : (is_index ? KindIndex : KindLine);
      pix_idx_q  <= pix_cnt_q;
      word_idx_q <= word_cnt_q;
      marker_q   <= is_pixel ? '0 : payload;
      for (int r = 0; r < MaxRegions; r++) begin
        total_q[r] <= (is_pixel && r < NumRegions) ? acc_q[r] : '0;
      end
      done_q     <= done;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = kind_q;
  assign res_o.pixel_index  = pix_idx_q;
  assign res_o.word_index   = word_idx_q;
  assign res_o.marker_value = marker_q;
  assign res_o.roi0_total   = total_q[0];
  assign res_o.roi1_total   = total_q[1];
  assign res_o.roi2_total   = total_q[2];
  assign res_o.scan_done    = done_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_done_only_on_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.scan_done |-> res_o.kind == KindLine)
    else $error("scan_done on a result that is not a line break");

  a_acc_clear_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_pixel |=> (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0))
    else $error("accumulators not cleared after pixel end");

  a_counters_clear_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && done |=> (pix_cnt_q == '0) && (word_cnt_q == '0))
    else $error("counters not cleared at scan completion");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |=> out_valid_q && $stable(word_idx_q))
    else $error("pending result lost or overwritten");

  a_scan_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(scan_w_q) && $stable(scan_h_q) |=>
      scan_total_q == PixelW'({12'd0, $past(scan_w_q)} * {12'd0, $past(scan_h_q)}))
    else $error("scan size product out of step with dimensions");

endmodule
